>>> hdl/hatc_pkg.sv
// shared types, codes and constants of the histogram tone curve block
package hatc_pkg;

  localparam int FRAC = 17;
  localparam int DIV_NW = 66;
  localparam int DIV_DW = 40;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 25;
  localparam logic [23:0] SPAN_MIN = 24'd249037;
  localparam logic [31:0] PCT_RECIP = 32'h51EB_851F;
  localparam int PCT_SHIFT = 37;

  typedef struct packed {
    logic        operation;
    logic [31:0] bin_value;
    logic        last_bin;
    logic [15:0] query_code;
  } hatc_in_t;

  typedef struct packed {
    logic [15:0] mapped_code;
    logic        applicable;
  } hatc_out_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BINS   = 3'd0,
    CFG_SPAN   = 3'd1,
    CFG_SLOPE  = 3'd2,
    CFG_OFFSET = 3'd3,
    CFG_DMIN   = 3'd4,
    CFG_DMAX   = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_QUERY_IN, OP_FILL, OP_TOL_DIV, OP_MUL_NUM,
    OP_CEIL_DIV, OP_CEIL_SET, OP_TRIM_RD, OP_TRIM_WR, OP_TRIM_END, OP_ACC_RD,
    OP_ACC_WR, OP_FINISH, OP_Q_NA, OP_Q_MIN, OP_Q_MAX, OP_Q_RD_HI, OP_Q_RD_LO,
    OP_Q_MUL_LO, OP_Q_MUL_HI, OP_Q_SCALE, OP_Q_DIV, OP_Q_FIN, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILL, ST_CHECK, ST_MUL, ST_CEIL, ST_CEIL_W, ST_TRIM_RD,
    ST_TRIM_WR, ST_TRIM_END, ST_ACC_RD, ST_ACC_WR, ST_FINISH, ST_Q_CHK, ST_Q_RD_LO,
    ST_Q_MUL_LO, ST_Q_MUL_HI, ST_Q_SCALE, ST_Q_DIV, ST_Q_DIV_W, ST_Q_OUT
  } state_t;

  typedef struct packed {
    logic fill_done;
    logic k_last;
    logic skip;
    logic trim_more;
    logic curve_ready;
    logic pos_le0;
    logic idx_ge;
    logic div_done;
    logic div_busy;
    logic out_blocked;
  } dp_stat_t;

endpackage

>>> hdl/hatc_div.sv
// restoring divider, one quotient bit per cycle
module hatc_div import hatc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r, d_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign diff = trial - {1'b0, d_r};
  assign ge = trial >= {1'b0, d_r};
  assign rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/hatc_dp.sv
// datapath: config registers, bin memory, trim and cumulative pass, query math
module hatc_dp import hatc_pkg::*; #(
  parameter int MAX_BINS = 1024,
  parameter int CODE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_op_t            op,
  output dp_stat_t          stat,
  input  hatc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hatc_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int NBW = $clog2(MAX_BINS + 1);
  localparam int CW = (NBW > 11) ? NBW : 11;
  localparam int PW = CODE_BITS + 27;
  localparam int IW = PW - 1 - FRAC;
  localparam logic [18:0] CMAX = 19'((1 << CODE_BITS) - 1);

  // config
  logic [10:0]        bins_r;
  logic [23:0]        span_cfg_r, slope_r;
  logic [24:0]        offset_r;
  logic [15:0]        dmin_r, dmax_r;

  // histogram and curve state
  logic [NBW-1:0]     load_idx_r, n_r, k_r, n_cur, ld_idx_nxt;
  logic [31:0]        total_r, scale_r, h_r, tol_r, acc_r;
  logic               ready_r;
  logic [23:0]        span_r;
  logic [55:0]        p1_r;
  logic [32:0]        ceil_r;
  logic [47:0]        trimmed_r;
  logic [63:0]        tol_prod;

  // query
  logic signed [PW-1:0] pos_r, pos_nxt, off_ext;
  logic [CODE_BITS+24:0] qprod;
  logic [31:0]        hi_r, lo;
  logic [49:0]        m_r, interp_r, hs, ic;
  logic [DIV_NW-1:0]  prod_r;
  hatc_out_t          res_r, out_data_r;
  logic               out_valid_r;

  // memory
  logic [31:0]        mem [MAX_BINS];
  logic [31:0]        mem_q_r, wd;
  logic [AW-1:0]      wa, ra;
  logic               we;

  // divider
  logic               div_start, div_busy, div_done;
  logic [DIV_NW-1:0]  div_n, div_q;
  logic [DIV_DW-1:0]  div_d;

  logic [CW-1:0]      bins_ext;
  logic               ld_wr;
  logic [32:0]        ld_sum, acc_sum;
  logic [31:0]        ld_base, acc_sat;
  logic [NBW+21:0]    den2;
  logic [IW-1:0]      idx;
  logic [FRAC-1:0]    f;
  logic [15:0]        range;
  logic [34:0]        xq;
  logic [35:0]        rsum;
  logic [18:0]        val;
  logic               trim_hit;

  hatc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    bins_ext = CW'(bins_r);
    if (bins_ext == '0) begin
      n_cur = NBW'(1);
    end else if (bins_ext > CW'(MAX_BINS)) begin
      n_cur = NBW'(MAX_BINS);
    end else begin
      n_cur = NBW'(bins_ext);
    end
  end

  assign ld_wr = load_idx_r < n_cur;
  assign ld_base = (load_idx_r == '0) ? 32'd0 : total_r;
  assign ld_sum = {1'b0, ld_base} + {1'b0, in_data.bin_value};
  assign ld_idx_nxt = ld_wr ? load_idx_r + 1'b1 : load_idx_r;

  assign tol_prod = total_r * PCT_RECIP;

  assign den2 = ({n_r, 5'b0, 16'b0} + {1'b0, n_r, 2'b0, 16'b0}) + {2'b0, n_r, 1'b0, 16'b0};
  assign trim_hit = {1'b0, mem_q_r} > ceil_r;
  assign acc_sum = {1'b0, acc_r} + {1'b0, mem_q_r};
  assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

  assign qprod = {in_data.query_code[CODE_BITS-1:0], 1'b1} * slope_r;
  assign off_ext = {{(PW-26){offset_r[24]}}, offset_r, 1'b0};
  assign pos_nxt = $signed({2'b00, qprod}) + off_ext;
  assign idx = pos_r[PW-2:FRAC];
  assign f = pos_r[FRAC-1:0];
  assign lo = (idx == '0) ? 32'd0 : mem_q_r;
  assign hs = {1'b0, scale_r, 17'b0};
  assign ic = (interp_r > hs) ? hs : interp_r;
  assign range = (dmax_r >= dmin_r) ? dmax_r - dmin_r : 16'd0;
  assign xq = div_q[34:0];
  assign rsum = {1'b0, xq} + {3'b0, dmin_r, 17'b0} + 36'h0_0001_0000;
  assign val = rsum[35:17];

  // memory ports
  always_comb begin
    we = 1'b0;
    wa = k_r[AW-1:0];
    wd = 32'd0;
    ra = k_r[AW-1:0];
    unique case (op)
      OP_LOAD: begin
        we = ld_wr;
        wa = load_idx_r[AW-1:0];
        wd = in_data.bin_value;
      end
      OP_FILL: we = 1'b1;
      OP_TRIM_WR: begin
        we = trim_hit;
        wd = ceil_r[31:0];
      end
      OP_ACC_WR: begin
        we = 1'b1;
        wd = acc_sat;
      end
      OP_Q_RD_HI: ra = idx[AW-1:0];
      OP_Q_RD_LO: ra = idx[AW-1:0] - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q_r <= mem[ra];
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_n = DIV_NW'(prod_r);
    div_d = DIV_DW'(scale_r);
    unique case (op)
      OP_CEIL_DIV: begin
        div_start = 1'b1;
        div_n = DIV_NW'({p1_r, 3'b0}) + DIV_NW'({p1_r, 1'b0}) + DIV_NW'(den2[NBW+21:1]);
        div_d = DIV_DW'(den2);
      end
      OP_Q_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= 11'd1024;
      span_cfg_r <= '0;
      slope_r <= '0;
      offset_r <= '0;
      dmin_r <= '0;
      dmax_r <= 16'hFFFF;
      load_idx_r <= '0;
      total_r <= '0;
      ready_r <= 1'b0;
      scale_r <= '0;
      n_r <= NBW'(1);
      k_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BINS: bins_r <= cfg_data[10:0];
          CFG_SPAN: span_cfg_r <= cfg_data[23:0];
          CFG_SLOPE: slope_r <= cfg_data[23:0];
          CFG_OFFSET: offset_r <= cfg_data;
          CFG_DMIN: dmin_r <= cfg_data[15:0];
          CFG_DMAX: dmax_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_LOAD: begin
          total_r <= ld_wr ? (ld_sum[32] ? 32'hFFFF_FFFF : ld_sum[31:0]) : ld_base;
          if (load_idx_r == '0) begin
            ready_r <= 1'b0;
          end
          if (in_data.last_bin) begin
            load_idx_r <= '0;
            ready_r <= 1'b0;
            scale_r <= '0;
            n_r <= n_cur;
            k_r <= ld_idx_nxt;
          end else begin
            load_idx_r <= ld_idx_nxt;
          end
        end
        OP_FILL, OP_TRIM_WR, OP_ACC_WR: k_r <= k_r + 1'b1;
        OP_CEIL_SET, OP_TRIM_END: k_r <= '0;
        OP_FINISH: begin
          ready_r <= h_r != '0;
          scale_r <= h_r;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: span_r <= span_cfg_r;
      OP_QUERY_IN: pos_r <= pos_nxt;
      OP_TOL_DIV: begin
        h_r <= total_r;
        tol_r <= {5'b0, tol_prod[63:PCT_SHIFT]};
      end
      OP_MUL_NUM: p1_r <= h_r * span_r;
      OP_CEIL_SET: begin
        ceil_r <= (div_q[DIV_NW-1:32] != '0) ? 33'h1_0000_0000 : {1'b0, div_q[31:0]};
        trimmed_r <= '0;
      end
      OP_TRIM_WR: begin
        if (trim_hit) begin
          trimmed_r <= trimmed_r + 48'(mem_q_r - ceil_r[31:0]);
        end
      end
      OP_TRIM_END: begin
        h_r <= (trimmed_r < {16'b0, h_r}) ? h_r - trimmed_r[31:0] : 32'd0;
        acc_r <= '0;
      end
      OP_ACC_WR: acc_r <= acc_sat;
      OP_Q_NA: res_r <= '{mapped_code: 16'd0, applicable: 1'b0};
      OP_Q_MIN: res_r <= '{mapped_code: ({3'b0, dmin_r} > CMAX) ? CMAX[15:0] : dmin_r,
                           applicable: 1'b1};
      OP_Q_MAX: res_r <= '{mapped_code: ({3'b0, dmax_r} > CMAX) ? CMAX[15:0] : dmax_r,
                           applicable: 1'b1};
      OP_Q_RD_LO: hi_r <= mem_q_r;
      OP_Q_MUL_LO: m_r <= lo * (18'(1 << FRAC) - {1'b0, f});
      OP_Q_MUL_HI: interp_r <= m_r + 50'(hi_r) * 50'(f);
      OP_Q_SCALE: prod_r <= ic * range;
      OP_Q_FIN: res_r <= '{mapped_code: (val > CMAX) ? CMAX[15:0] : val[15:0],
                           applicable: 1'b1};
      OP_OUT: out_data_r <= res_r;
      default: ;
    endcase
  end

  assign stat.fill_done = k_r >= n_r;
  assign stat.k_last = k_r == n_r - 1'b1;
  assign stat.skip = (span_r < SPAN_MIN) || (total_r == '0);
  assign stat.trim_more = trimmed_r > {16'b0, tol_r};
  assign stat.curve_ready = ready_r;
  assign stat.pos_le0 = pos_r[PW-1] || (pos_r == '0);
  assign stat.idx_ge = idx >= IW'(n_r);
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;
  assign stat.out_blocked = out_valid_r && out_stall;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> hdl/hatc_ctrl.sv
// controller state machine sequencing loads, curve build and queries
module hatc_ctrl import hatc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_query,
  input  logic     in_last,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_query) begin
            state_nxt = ST_Q_CHK;
          end else if (in_last) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: if (stat.fill_done) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.skip ? ST_IDLE : ST_MUL;
      ST_MUL: state_nxt = ST_CEIL;
      ST_CEIL: state_nxt = ST_CEIL_W;
      ST_CEIL_W: if (stat.div_done) state_nxt = ST_TRIM_RD;
      ST_TRIM_RD: state_nxt = ST_TRIM_WR;
      ST_TRIM_WR: state_nxt = stat.k_last ? ST_TRIM_END : ST_TRIM_RD;
      ST_TRIM_END: state_nxt = stat.trim_more ? ST_MUL : ST_ACC_RD;
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: state_nxt = stat.k_last ? ST_FINISH : ST_ACC_RD;
      ST_FINISH: state_nxt = ST_IDLE;
      ST_Q_CHK: begin
        if (!stat.curve_ready || stat.pos_le0 || stat.idx_ge) begin
          state_nxt = ST_Q_OUT;
        end else begin
          state_nxt = ST_Q_RD_LO;
        end
      end
      ST_Q_RD_LO: state_nxt = ST_Q_MUL_LO;
      ST_Q_MUL_LO: state_nxt = ST_Q_MUL_HI;
      ST_Q_MUL_HI: state_nxt = ST_Q_SCALE;
      ST_Q_SCALE: state_nxt = ST_Q_DIV;
      ST_Q_DIV: state_nxt = ST_Q_DIV_W;
      ST_Q_DIV_W: if (stat.div_done) state_nxt = ST_Q_OUT;
      ST_Q_OUT: if (!stat.out_blocked) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op = in_query ? OP_QUERY_IN : OP_LOAD;
        end
      end
      ST_FILL: if (!stat.fill_done) op = OP_FILL;
      ST_CHECK: if (!stat.skip) op = OP_TOL_DIV;
      ST_MUL: op = OP_MUL_NUM;
      ST_CEIL: op = OP_CEIL_DIV;
      ST_CEIL_W: if (stat.div_done) op = OP_CEIL_SET;
      ST_TRIM_RD: op = OP_TRIM_RD;
      ST_TRIM_WR: op = OP_TRIM_WR;
      ST_TRIM_END: op = OP_TRIM_END;
      ST_ACC_RD: op = OP_ACC_RD;
      ST_ACC_WR: op = OP_ACC_WR;
      ST_FINISH: op = OP_FINISH;
      ST_Q_CHK: begin
        priority if (!stat.curve_ready) begin
          op = OP_Q_NA;
        end else if (stat.pos_le0) begin
          op = OP_Q_MIN;
        end else if (stat.idx_ge) begin
          op = OP_Q_MAX;
        end else begin
          op = OP_Q_RD_HI;
        end
      end
      ST_Q_RD_LO: op = OP_Q_RD_LO;
      ST_Q_MUL_LO: op = OP_Q_MUL_LO;
      ST_Q_MUL_HI: op = OP_Q_MUL_HI;
      ST_Q_SCALE: op = OP_Q_SCALE;
      ST_Q_DIV: op = OP_Q_DIV;
      ST_Q_DIV_W: if (stat.div_done) op = OP_Q_FIN;
      ST_Q_OUT: if (!stat.out_blocked) op = OP_OUT;
      default: op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/histogram_adjust_tone_curve.sv
// top level of the histogram adjustment tone curve block
//
//  channel  direction  handshake          payload
//  in_      request    in_valid/in_stall  hatc_in_t  (load bin or query code)
//  out_     result     out_valid/out_stall hatc_out_t (one per query)
//  cfg_     write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// loads are taken in idle; a query runs through the 66-step shared divider
// last bin: zero fill of unloaded bins, the checks and tolerance, then per trim pass a
// ceiling divide plus read/write sweep, then a read/write sweep to accumulate
// reset clears control state only; bin memory is not cleared
// in_stall is high whenever the controller is away from idle
// a finished result waits in the output register while loads keep going
module histogram_adjust_tone_curve import hatc_pkg::*; #(
  parameter int MAX_BINS = 1024,
  parameter int CODE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hatc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hatc_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  dp_op_t   op;
  dp_stat_t stat;

  hatc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_query(in_data.operation),
    .in_last(in_data.last_bin), .in_stall(in_stall), .stat(stat), .op(op)
  );

  hatc_dp #(.MAX_BINS(MAX_BINS), .CODE_BITS(CODE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .stat(stat), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

`ifndef ASSERT_OFF
  a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> in_stall) else $error("input taken while divider runs");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.operation && !out_valid) |=> !out_valid)
    else $error("result produced by a load");

  a_na_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.applicable) |-> out_data.mapped_code == 16'd0)
    else $error("not applicable result with nonzero code");
`endif

endmodule
